FILE: rtl/fmi_pkg.sv
// ----------------------------------------------------------------------------
// fmi_pkg: shared constants for the Fermat modular inverse block
// Field widths, stream bus widths and the small modulus limit.
// ----------------------------------------------------------------------------
package fmi_pkg;

    // Bits of the modulus kept from a configuration write (8..31)
    localparam int MODULUS_BITS = 31;

    // Field widths
    localparam int OPERAND_W = 31;
    localparam int INVERSE_W = 31;
    localparam int MODCFG_W  = 31;

    // Stream bus data widths, fields padded to whole bytes
    localparam int S_TDATA_W = ((OPERAND_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((INVERSE_W + 7) / 8) * 8;

    // Reset value of the modulus register
    localparam logic [MODULUS_BITS-1:0] MODULUS_RESET = MODULUS_BITS'(3);

    // Moduli below this value give a zero result
    localparam logic [MODULUS_BITS-1:0] MODULUS_MIN = MODULUS_BITS'(3);

    // Fermat exponent offset: exponent is modulus minus this
    localparam logic [MODULUS_BITS-1:0] EXP_OFFSET = MODULUS_BITS'(2);

endpackage

FILE: rtl/fermat_modular_inverse.sv
// ----------------------------------------------------------------------------
// fermat_modular_inverse: modular inverse by Fermat's little theorem
// Returns operand^(modulus-2) mod modulus using right-to-left square and
// multiply over one shared bit-serial interleaved multiply-reduce unit.
// ----------------------------------------------------------------------------
// Sequence: the operand is first reduced; then each exponent bit takes a
// check, a multiply into the accumulator when the bit is set, and a square;
// a last check and the output load follow.
// Throughput: one transaction at a time; the next input is taken in the cycle
// after the result is loaded. A modulus below 3 gives zero from the finishing
// state. Reset: asynchronous, active low; modulus returns to 3.
module fermat_modular_inverse
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream: [30:0] operand
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fmi_pkg::S_TDATA_W-1:0] s_tdata,
    // Output stream: [30:0] inverse
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fmi_pkg::M_TDATA_W-1:0] m_tdata,
    // Modulus register write
    input  logic                          cfg_we,
    input  logic [fmi_pkg::MODCFG_W-1:0]  cfg_wdata
);

    import fmi_pkg::*;

    localparam int MW    = MODULUS_BITS;
    localparam int BW    = (OPERAND_W > MW) ? OPERAND_W : MW;
    localparam int CNT_W = $clog2(BW);
    localparam int TW    = MW + 2;
    localparam int DW    = MW + 3;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_MUL_ACC,
        S_MUL_SQR,
        S_FINISH
    } state_t;

    state_t             state_reg,   state_next;
    logic [MW-1:0]      modulus_reg;
    logic [MW-1:0]      acc_reg,     acc_next;
    logic [MW-1:0]      base_reg,    base_next;
    logic [MW-1:0]      exp_reg,     exp_next;
    logic [MW-1:0]      mul_a_reg,   mul_a_next;
    logic [BW-1:0]      mul_b_reg,   mul_b_next;
    logic [MW-1:0]      mul_r_reg,   mul_r_next;
    logic [CNT_W-1:0]   mul_cnt_reg, mul_cnt_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [INVERSE_W-1:0] out_reg,   out_next;

    logic [TW-1:0]      step_sum;
    logic [DW-1:0]      step_d1;
    logic [DW-1:0]      step_d2;
    logic [MW-1:0]      step_r;
    logic               mul_last;
    logic               in_xfer;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

    // Hold the modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            modulus_reg <= MW'(cfg_wdata);
        end
    end

    // Shared multiply-reduce step: r = (2r + bit*a) mod m, with r, a < m
    always_comb
    begin
        step_sum = {1'b0, mul_r_reg, 1'b0}
                 + (mul_b_reg[BW-1] ? TW'(mul_a_reg) : TW'(0));
        step_d1  = DW'(step_sum) - DW'(modulus_reg);
        step_d2  = DW'(step_sum) - DW'({modulus_reg, 1'b0});
        if (!step_d2[DW-1])
        begin
            step_r = step_d2[MW-1:0];
        end
        else if (!step_d1[DW-1])
        begin
            step_r = step_d1[MW-1:0];
        end
        else
        begin
            step_r = step_sum[MW-1:0];
        end
    end

    assign mul_last = (mul_cnt_reg == CNT_W'(BW - 1));

    // Sequencer: next state and datapath values
    always_comb
    begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        base_next     = base_reg;
        exp_next      = exp_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        mul_r_next    = mul_r_reg;
        mul_cnt_next  = mul_cnt_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;

        // Drop the result once the output transaction completes
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // Advance the multiply-reduce unit in the multiply states
        if (state_reg == S_REDUCE || state_reg == S_MUL_ACC || state_reg == S_MUL_SQR)
        begin
            mul_r_next   = step_r;
            mul_b_next   = mul_b_reg << 1;
            mul_cnt_next = mul_last ? CNT_W'(0) : mul_cnt_reg + CNT_W'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (modulus_reg < MODULUS_MIN)
                    begin
                        acc_next   = '0;
                        base_next  = '0;
                        exp_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        // Reduce the operand as 1 * operand mod m
                        mul_a_next   = MW'(1);
                        mul_b_next   = BW'(s_tdata[OPERAND_W-1:0]);
                        mul_r_next   = '0;
                        mul_cnt_next = '0;
                        state_next   = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (mul_last)
                begin
                    base_next  = step_r;
                    acc_next   = MW'(1);
                    exp_next   = modulus_reg - EXP_OFFSET;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                mul_r_next   = '0;
                mul_cnt_next = '0;
                if (exp_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else if (exp_reg[0])
                begin
                    mul_a_next = acc_reg;
                    mul_b_next = BW'(base_reg);
                    state_next = S_MUL_ACC;
                end
                else
                begin
                    mul_a_next = base_reg;
                    mul_b_next = BW'(base_reg);
                    state_next = S_MUL_SQR;
                end
            end
            S_MUL_ACC:
            begin
                if (mul_last)
                begin
                    acc_next     = step_r;
                    mul_a_next   = base_reg;
                    mul_b_next   = BW'(base_reg);
                    mul_r_next   = '0;
                    mul_cnt_next = '0;
                    state_next   = S_MUL_SQR;
                end
            end
            S_MUL_SQR:
            begin
                if (mul_last)
                begin
                    base_next  = step_r;
                    exp_next   = exp_reg >> 1;
                    state_next = S_CHECK;
                end
            end
            S_FINISH:
            begin
                // Load the output register once it is free
                if (!m_tvalid_reg || m_tready)
                begin
                    out_next      = INVERSE_W'(acc_reg);
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, datapath and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            out_reg      <= '0;
            mul_cnt_reg  <= '0;
            acc_reg      <= MW'(1);
            base_reg     <= '0;
            exp_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            out_reg      <= out_next;
            mul_cnt_reg  <= mul_cnt_next;
            acc_reg      <= acc_next;
            base_reg     <= base_next;
            exp_reg      <= exp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        mul_r_reg <= mul_r_next;
    end

    // A new input transaction closes the input side on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a transaction is in progress");

    // The running remainder stays below the modulus
    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_ACC || state_reg == S_MUL_SQR) |-> (mul_r_reg < modulus_reg))
        else $error("multiply-reduce remainder not below modulus");

    // A result appears only out of the finishing state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside the finishing state");

    // Each completed square consumes exactly one exponent bit
    a_exp_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_SQR && mul_last) |=> (exp_reg == ($past(exp_reg) >> 1)))
        else $error("exponent not shifted after squaring");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fermat_modular_inverse
// Streams operands through the block under a range of moduli (reset value,
// largest prime, out-of-range, even and composite, random) with random
// source gaps and sink stalls. Every result is checked against an
// in-bench square-and-multiply power computed at 64-bit width.
// ----------------------------------------------------------------------------
module testbench;

    import fmi_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 12;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYC    = 2100;
    localparam int MAX_GAP     = 10;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we;
    logic [MODCFG_W-1:0]    cfg_wdata;

    // Bench copy of the modulus register and the expected inverses in order
    logic [MODULUS_BITS-1:0] cur_modulus;
    logic [INVERSE_W-1:0]    pending_inverses[$];
    int                      error_count;
    int                      quiet_cycles;
    bit                      no_idle;

    fermat_modular_inverse u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Generate the clock
    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // Compute operand^(modulus-2) mod modulus; zero for a modulus below three
    function automatic logic [INVERSE_W-1:0] fermat_power(logic [OPERAND_W-1:0] x,
                                                          logic [MODULUS_BITS-1:0] m);
        longint unsigned acc;
        longint unsigned base;
        longint unsigned expo;
        longint unsigned mm;
        mm = longint'(m);
        if (m < MODULUS_MIN)
            return '0;
        acc  = 1;
        base = longint'(x) % mm;
        expo = mm - longint'(EXP_OFFSET);
        while (expo != 0)
        begin
            if (expo[0])
                acc = (acc * base) % mm;
            base = (base * base) % mm;
            expo = expo >> 1;
        end
        return acc[INVERSE_W-1:0];
    endfunction

    function automatic bit check_prime(longint unsigned n);
        longint unsigned d;
        if (n < 2)
            return 1'b0;
        if (n < 4)
            return 1'b1;
        if (n[0] == 1'b0)
            return 1'b0;
        for (d = 3; d * d <= n; d += 2)
            if (n % d == 0)
                return 1'b0;
        return 1'b1;
    endfunction

    // Random value with its top bit at a random position from bit 1 up
    function automatic logic [MODULUS_BITS-1:0] random_width_value();
        int                      w;
        logic [MODULUS_BITS-1:0] v;
        w = $urandom_range(2, MODULUS_BITS);
        v = MODULUS_BITS'($urandom);
        v = v & ((MODULUS_BITS'(1) << w) - 1'b1);
        v[w-1] = 1'b1;
        return v;
    endfunction

    function automatic logic [MODULUS_BITS-1:0] random_prime();
        logic [MODULUS_BITS-1:0] v;
        v = random_width_value() | MODULUS_BITS'(1);
        if (v < MODULUS_MIN)
            v = MODULUS_MIN;
        while (!check_prime(longint'(v)))
        begin
            v = v + MODULUS_BITS'(2);
            if (v < MODULUS_MIN)
                v = MODULUS_MIN;
        end
        return v;
    endfunction

    function automatic logic [OPERAND_W-1:0] pick_operand(logic [MODULUS_BITS-1:0] m);
        logic [OPERAND_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = OPERAND_W'(m - 1'b1);
            2:       v = OPERAND_W'($urandom_range(1, 16));
            3:       v = OPERAND_W'(m);
            4:       v = '1;
            default: v = OPERAND_W'($urandom);
        endcase
        return v;
    endfunction

    // Present one operand after a random gap and hold it until the transaction
    task automatic send_operand(logic [OPERAND_W-1:0] x);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(x);
        do
            @(posedge clk);
        while (!s_tready);
        pending_inverses.push_back(fermat_power(x, cur_modulus));
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_inverses.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_modulus(logic [MODCFG_W-1:0] v);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_modulus = v[MODULUS_BITS-1:0];
    endtask

    // Reset value of the modulus: no write yet
    task automatic test_reset_modulus();
        send_operand('0);
        send_operand(OPERAND_W'(1));
        send_operand(OPERAND_W'(2));
        send_operand('1);
    endtask

    // Largest prime modulus with operand extremes, operand equal to modulus; then modulus 65537
    task automatic test_largest_prime();
        write_modulus('1);
        send_operand('0);
        send_operand(OPERAND_W'(1));
        send_operand(OPERAND_W'(2));
        send_operand(OPERAND_W'(32'h7FFF_FFFE));
        send_operand('1);
        write_modulus(MODCFG_W'(65537));
        send_operand(OPERAND_W'(65536));
        send_operand(OPERAND_W'(12345));
    endtask

    // Moduli 0, 1 and 2 are out of range and return zero
    task automatic test_small_modulus();
        int k;
        for (k = 0; k < 3; k++)
        begin
            write_modulus(MODCFG_W'(k));
            send_operand('1);
            send_operand(OPERAND_W'(5));
        end
    endtask

    // Composite and even moduli give the plain power, operands above modulus
    task automatic test_composite_modulus();
        write_modulus(MODCFG_W'(15));
        send_operand(OPERAND_W'(4));
        send_operand(OPERAND_W'(20));
        send_operand('0);
        write_modulus(MODCFG_W'(10));
        send_operand(OPERAND_W'(3));
    endtask

    // Random moduli, each followed by a run of random operands
    task automatic test_random_traffic();
        int                      phase;
        int                      k;
        logic [MODULUS_BITS-1:0] m;
        for (phase = 0; phase < 10; phase++)
        begin
            case ($urandom_range(0, 7))
                0:       m = MODULUS_BITS'($urandom_range(0, 2));
                1:       m = '1;
                2:       m = random_width_value();
                3:       m = random_width_value() | MODULUS_BITS'(1);
                4:       m = MODULUS_BITS'($urandom);
                default: m = random_prime();
            endcase
            write_modulus(m);
            no_idle = (phase % 4 == 3);
            for (k = 0; k < 27; k++)
                send_operand(pick_operand(m));
        end
        no_idle = 1'b0;
        write_modulus(MODULUS_RESET);
        for (k = 0; k < 4; k++)
            send_operand(pick_operand(MODULUS_RESET));
    endtask

    // Take results after a random stall per transaction
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        logic [INVERSE_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_inverses.size() == 0)
            begin
                $error("unexpected result: inverse actual %0d", m_tdata[INVERSE_W-1:0]);
                error_count++;
            end
            else
            begin
                want = pending_inverses.pop_front();
                if (m_tdata[INVERSE_W-1:0] !== want)
                begin
                    $error("inverse mismatch: expected %0d actual %0d",
                           want, m_tdata[INVERSE_W-1:0]);
                    error_count++;
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        cur_modulus = MODULUS_RESET;
        error_count = 0;
        quiet_cycles = 0;
        no_idle     = 1'b0;
        repeat (RESET_CYC) @(negedge clk);
        rst_n = 1'b1;

        test_reset_modulus();
        test_largest_prime();
        test_small_modulus();
        test_composite_modulus();
        test_random_traffic();

        // Hold off for stray results after the last expected one
        drain_results();
        repeat (TAIL_CYC) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
